/* design/pmes_pkg.sv */
package pmes_pkg;

   localparam int WORD_WIDTH = 32;
   localparam int FRAC_BITS  = 16;
   localparam int MAG_WIDTH  = WORD_WIDTH + FRAC_BITS + 1;
   localparam int PROD_WIDTH = 2 * WORD_WIDTH;

   localparam int ORDER_WIDTH = 2;
   localparam int STEP_WIDTH  = FRAC_BITS + 1;
   localparam int UPAR_WIDTH  = WORD_WIDTH - 1;
   localparam int INDEX_WIDTH = 3;

   typedef logic signed [WORD_WIDTH-1:0] word_type;
   typedef logic [WORD_WIDTH-1:0]        umag_type;
   typedef logic [MAG_WIDTH-1:0]         mag_type;

   localparam longint ONE_Q = longint'(1) << FRAC_BITS;

   localparam word_type WORD_MAX = word_type'((longint'(1) << (WORD_WIDTH - 1)) - 1);
   localparam word_type WORD_MIN = word_type'(-(longint'(1) << (WORD_WIDTH - 1)));

   localparam umag_type STOP_SPEED = umag_type'((ONE_Q + 500) / 1000);

   localparam logic [ORDER_WIDTH-1:0] ORDER_RESET = ORDER_WIDTH'(1);
   localparam logic [STEP_WIDTH-1:0]  STEP_RESET  = STEP_WIDTH'((ONE_Q + 50) / 100);
   localparam word_type               GROW_RESET  = word_type'((ONE_Q + 5) / 10);
   localparam logic [UPAR_WIDTH-1:0]  FRIC_RESET  = UPAR_WIDTH'(ONE_Q);
   localparam logic [UPAR_WIDTH-1:0]  STIC_RESET  = UPAR_WIDTH'(ONE_Q);
   localparam word_type               MGAIN_RESET = word_type'(ONE_Q);
   localparam word_type               BEMF_RESET  = '0;
   localparam logic [UPAR_WIDTH-1:0]  MASS_RESET  = UPAR_WIDTH'((ONE_Q + 5) / 10);
   localparam word_type               TEMP_RESET  = word_type'((47 * ONE_Q + 5) / 10);
   localparam word_type               DISP_RESET  = word_type'((33 * ONE_Q + 5) / 10);

   localparam logic [ORDER_WIDTH-1:0] MODE_FIRST  = ORDER_WIDTH'(1);
   localparam logic [ORDER_WIDTH-1:0] MODE_SECOND = ORDER_WIDTH'(2);

   localparam logic [INDEX_WIDTH-1:0] REG_PLANT_ORDER  = INDEX_WIDTH'(0);
   localparam logic [INDEX_WIDTH-1:0] REG_TIME_STEP    = INDEX_WIDTH'(1);
   localparam logic [INDEX_WIDTH-1:0] REG_GROWTH_COEF  = INDEX_WIDTH'(2);
   localparam logic [INDEX_WIDTH-1:0] REG_FRICTION     = INDEX_WIDTH'(3);
   localparam logic [INDEX_WIDTH-1:0] REG_STICTION     = INDEX_WIDTH'(4);
   localparam logic [INDEX_WIDTH-1:0] REG_MOTOR_GAIN   = INDEX_WIDTH'(5);
   localparam logic [INDEX_WIDTH-1:0] REG_BACKEMF_GAIN = INDEX_WIDTH'(6);
   localparam logic [INDEX_WIDTH-1:0] REG_MASS         = INDEX_WIDTH'(7);

   function automatic umag_type abs_word(input word_type a);
      umag_type r;
      r = a[WORD_WIDTH-1] ? umag_type'(-a) : umag_type'(a);
      return r;
   endfunction

   function automatic word_type sat_add(input word_type a, input word_type b);
      logic signed [WORD_WIDTH:0] s;
      s = {a[WORD_WIDTH-1], a} + {b[WORD_WIDTH-1], b};
      if (s[WORD_WIDTH] != s[WORD_WIDTH-1]) begin
         return s[WORD_WIDTH] ? WORD_MIN : WORD_MAX;
      end
      return s[WORD_WIDTH-1:0];
   endfunction

   function automatic word_type sat_neg(input word_type a);
      word_type r;
      r = (a == WORD_MIN) ? WORD_MAX : -a;
      return r;
   endfunction

   function automatic word_type sat_mag(input logic neg, input mag_type m);
      word_type r;
      if (!neg) begin
         r = (m > mag_type'(WORD_MAX)) ? WORD_MAX : word_type'(m[WORD_WIDTH-1:0]);
      end else if (m > mag_type'(umag_type'(WORD_MIN))) begin
         r = WORD_MIN;
      end else begin
         r = word_type'(-m[WORD_WIDTH-1:0]);
      end
      return r;
   endfunction

endpackage

/* design/plant_model_euler_step_top.sv */
// Channel   Direction  Ports
// req       in         req_valid, req_ready, req_control_effort
// rsp       out        rsp_valid, rsp_ready, rsp_plant_state, rsp_mode_error
// csr       in         csr_valid, csr_ready, csr_index, csr_data
//
// A first-order beat steps through M1_A to M1_F, a second-order beat through SNAP
// to DISP with a 49-step bit-serial divide by mass; an invalid mode goes straight
// to FIN. Request ready returns in the cycle after FIN fills the output register.
// One shared two-stage multiplier serves all products. A finished result waits in
// the output register while the next beat is accepted; a later result stalls until
// that register drains. Reset is synchronous; it restores state and settings only.
module plant_model_euler_step_top
   import pmes_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  word_type               req_control_effort,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output word_type               rsp_plant_state,
   output logic                   rsp_mode_error,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [INDEX_WIDTH-1:0] csr_index,
   input  logic [WORD_WIDTH-1:0]  csr_data
);

   localparam logic [4:0] ST_IDLE  = 5'd0;
   localparam logic [4:0] ST_M1_A  = 5'd1;
   localparam logic [4:0] ST_M1_B  = 5'd2;
   localparam logic [4:0] ST_M1_C  = 5'd3;
   localparam logic [4:0] ST_M1_D  = 5'd4;
   localparam logic [4:0] ST_M1_E  = 5'd5;
   localparam logic [4:0] ST_M1_F  = 5'd6;
   localparam logic [4:0] ST_SNAP  = 5'd7;
   localparam logic [4:0] ST_FRIC  = 5'd8;
   localparam logic [4:0] ST_BEMF  = 5'd9;
   localparam logic [4:0] ST_DECEL = 5'd10;
   localparam logic [4:0] ST_DRIVE = 5'd11;
   localparam logic [4:0] ST_MOTOR = 5'd12;
   localparam logic [4:0] ST_MWAIT = 5'd13;
   localparam logic [4:0] ST_FORCE = 5'd14;
   localparam logic [4:0] ST_DIV   = 5'd15;
   localparam logic [4:0] ST_ACC   = 5'd16;
   localparam logic [4:0] ST_AWAIT = 5'd17;
   localparam logic [4:0] ST_SPEED = 5'd18;
   localparam logic [4:0] ST_VEL   = 5'd19;
   localparam logic [4:0] ST_VWAIT = 5'd20;
   localparam logic [4:0] ST_DISP  = 5'd21;
   localparam logic [4:0] ST_FIN   = 5'd22;

   logic [4:0]             state_ff, state_in;
   logic [ORDER_WIDTH-1:0] order_ff, order_in;
   logic [STEP_WIDTH-1:0]  dt_ff, dt_in;
   word_type               grow_ff, grow_in;
   logic [UPAR_WIDTH-1:0]  fric_ff, fric_in;
   logic [UPAR_WIDTH-1:0]  stic_ff, stic_in;
   word_type               mgain_ff, mgain_in;
   word_type               bemf_ff, bemf_in;
   logic [UPAR_WIDTH-1:0]  mass_ff, mass_in;
   word_type               temp_ff, temp_in;
   word_type               disp_ff, disp_in;
   word_type               speed_ff, speed_in;
   word_type               last_ff, last_in;
   word_type               effort_ff, effort_in;
   word_type               tmp_ff, tmp_in;
   word_type               decel_ff, decel_in;
   logic                   err_ff, err_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   word_type               rsp_state_ff, rsp_state_in;
   logic                   rsp_err_ff, rsp_err_in;

   word_type mul_a, mul_b, mul_res;
   logic     div_start, div_done;
   word_type div_num, div_q;
   word_type dt_word, fric_word;
   logic     accept, out_free;

   pmes_mul u_mul (
      .clock  (clock),
      .op_a   (mul_a),
      .op_b   (mul_b),
      .result (mul_res)
   );

   pmes_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .numer  (div_num),
      .denom  (mass_ff),
      .done   (div_done),
      .quot   (div_q)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign dt_word   = word_type'({{(WORD_WIDTH-STEP_WIDTH){1'b0}}, dt_ff});
   assign fric_word = word_type'({1'b0, fric_ff});

   always_comb begin
      case (state_ff)
         ST_M1_A: begin
            mul_a = grow_ff;
            mul_b = temp_ff;
         end
         ST_M1_D: begin
            mul_a = tmp_ff;
            mul_b = dt_word;
         end
         ST_FRIC: begin
            mul_a = speed_ff;
            mul_b = fric_word;
         end
         ST_BEMF: begin
            mul_a = bemf_ff;
            mul_b = speed_ff;
         end
         ST_MOTOR: begin
            mul_a = mgain_ff;
            mul_b = tmp_ff;
         end
         ST_ACC: begin
            mul_a = tmp_ff;
            mul_b = dt_word;
         end
         ST_VEL: begin
            mul_a = speed_ff;
            mul_b = dt_word;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      order_in     = order_ff;
      dt_in        = dt_ff;
      grow_in      = grow_ff;
      fric_in      = fric_ff;
      stic_in      = stic_ff;
      mgain_in     = mgain_ff;
      bemf_in      = bemf_ff;
      mass_in      = mass_ff;
      temp_in      = temp_ff;
      disp_in      = disp_ff;
      speed_in     = speed_ff;
      last_in      = last_ff;
      effort_in    = effort_ff;
      tmp_in       = tmp_ff;
      decel_in     = decel_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_state_in = rsp_state_ff;
      rsp_err_in   = rsp_err_ff;
      div_start    = 1'b0;
      div_num      = sat_add(mul_res, decel_ff);

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid) begin
         case (csr_index)
            REG_PLANT_ORDER:  order_in = csr_data[ORDER_WIDTH-1:0];
            REG_TIME_STEP:    dt_in    = csr_data[STEP_WIDTH-1:0];
            REG_GROWTH_COEF:  grow_in  = word_type'(csr_data);
            REG_FRICTION:     fric_in  = csr_data[UPAR_WIDTH-1:0];
            REG_STICTION:     stic_in  = csr_data[UPAR_WIDTH-1:0];
            REG_MOTOR_GAIN:   mgain_in = word_type'(csr_data);
            REG_BACKEMF_GAIN: bemf_in  = word_type'(csr_data);
            REG_MASS:         mass_in  = csr_data[UPAR_WIDTH-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               effort_in = req_control_effort;
               err_in    = 1'b0;
               if (order_ff == MODE_FIRST) begin
                  state_in = ST_M1_A;
               end else if (order_ff == MODE_SECOND) begin
                  state_in = ST_SNAP;
               end else begin
                  err_in   = 1'b1;
                  state_in = ST_FIN;
               end
            end
         end
         ST_M1_A: state_in = ST_M1_B;
         ST_M1_B: state_in = ST_M1_C;
         ST_M1_C: begin
            tmp_in   = sat_add(mul_res, effort_ff);
            state_in = ST_M1_D;
         end
         ST_M1_D: state_in = ST_M1_E;
         ST_M1_E: state_in = ST_M1_F;
         ST_M1_F: begin
            temp_in  = sat_add(temp_ff, mul_res);
            last_in  = temp_in;
            state_in = ST_FIN;
         end
         ST_SNAP: begin
            if (abs_word(speed_ff) < STOP_SPEED) begin
               speed_in = '0;
               if (abs_word(effort_ff) < umag_type'(stic_ff)) begin
                  effort_in = '0;
               end
            end
            state_in = ST_FRIC;
         end
         ST_FRIC: state_in = ST_BEMF;
         ST_BEMF: state_in = ST_DECEL;
         ST_DECEL: begin
            decel_in = sat_neg(mul_res);
            state_in = ST_DRIVE;
         end
         ST_DRIVE: begin
            tmp_in   = sat_add(effort_ff, sat_neg(mul_res));
            state_in = ST_MOTOR;
         end
         ST_MOTOR: state_in = ST_MWAIT;
         ST_MWAIT: state_in = ST_FORCE;
         ST_FORCE: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               tmp_in   = div_q;
               state_in = ST_ACC;
            end
         end
         ST_ACC:   state_in = ST_AWAIT;
         ST_AWAIT: state_in = ST_SPEED;
         ST_SPEED: begin
            speed_in = sat_add(speed_ff, mul_res);
            state_in = ST_VEL;
         end
         ST_VEL:   state_in = ST_VWAIT;
         ST_VWAIT: state_in = ST_DISP;
         ST_DISP: begin
            disp_in  = sat_add(disp_ff, mul_res);
            last_in  = disp_in;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_state_in = last_ff;
               rsp_err_in   = err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         order_ff     <= ORDER_RESET;
         dt_ff        <= STEP_RESET;
         grow_ff      <= GROW_RESET;
         fric_ff      <= FRIC_RESET;
         stic_ff      <= STIC_RESET;
         mgain_ff     <= MGAIN_RESET;
         bemf_ff      <= BEMF_RESET;
         mass_ff      <= MASS_RESET;
         temp_ff      <= TEMP_RESET;
         disp_ff      <= DISP_RESET;
         speed_ff     <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         order_ff     <= order_in;
         dt_ff        <= dt_in;
         grow_ff      <= grow_in;
         fric_ff      <= fric_in;
         stic_ff      <= stic_in;
         mgain_ff     <= mgain_in;
         bemf_ff      <= bemf_in;
         mass_ff      <= mass_in;
         temp_ff      <= temp_in;
         disp_ff      <= disp_in;
         speed_ff     <= speed_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      effort_ff    <= effort_in;
      tmp_ff       <= tmp_in;
      decel_ff     <= decel_in;
      err_ff       <= err_in;
      rsp_state_ff <= rsp_state_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_plant_state = rsp_state_ff;
   assign rsp_mode_error  = rsp_err_ff;

endmodule

/* design/pmes_mul.sv */
module pmes_mul
   import pmes_pkg::*;
(
   input  logic     clock,
   input  word_type op_a,
   input  word_type op_b,
   output word_type result
);

   logic [PROD_WIDTH-1:0] prod_ff, prod_in;
   logic                  neg_ff, neg_in;
   word_type              res_ff, res_in;
   logic [PROD_WIDTH-1:0] rsum;

   always_comb begin
      prod_in = PROD_WIDTH'(abs_word(op_a)) * PROD_WIDTH'(abs_word(op_b));
      neg_in  = op_a[WORD_WIDTH-1] ^ op_b[WORD_WIDTH-1];
      rsum    = prod_ff + (PROD_WIDTH'(1) << (FRAC_BITS - 1));
      res_in  = sat_mag(neg_ff, MAG_WIDTH'(rsum >> FRAC_BITS));
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      neg_ff  <= neg_in;
      res_ff  <= res_in;
   end

   assign result = res_ff;

endmodule

/* design/pmes_div.sv */
module pmes_div
   import pmes_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  word_type              numer,
   input  logic [UPAR_WIDTH-1:0] denom,
   output logic                  done,
   output word_type              quot
);

   localparam int CNT_WIDTH = $clog2(MAG_WIDTH);
   localparam logic [CNT_WIDTH-1:0] LAST_STEP = CNT_WIDTH'(MAG_WIDTH - 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_WIDTH-1:0]  cnt_ff, cnt_in;
   mag_type               dvd_ff, dvd_in;
   logic [UPAR_WIDTH-1:0] rem_ff, rem_in;
   logic [UPAR_WIDTH-1:0] den_ff, den_in;
   logic                  neg_ff, neg_in;
   word_type              quot_ff, quot_in;
   logic [UPAR_WIDTH-1:0] den_fix;
   logic [UPAR_WIDTH:0]   trial;
   logic                  ge;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      quot_in = quot_ff;
      den_fix = (denom == '0) ? UPAR_WIDTH'(1) : denom;
      trial   = {rem_ff, dvd_ff[MAG_WIDTH-1]};
      ge      = trial >= {1'b0, den_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         den_in  = den_fix;
         neg_in  = numer[WORD_WIDTH-1];
         dvd_in  = (MAG_WIDTH'(abs_word(numer)) << FRAC_BITS)
                 + MAG_WIDTH'(den_fix >> 1);
      end else if (busy_ff) begin
         rem_in = ge ? UPAR_WIDTH'(trial - {1'b0, den_ff}) : UPAR_WIDTH'(trial);
         dvd_in = {dvd_ff[MAG_WIDTH-2:0], ge};
         cnt_in = cnt_ff + CNT_WIDTH'(1);
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            quot_in = sat_mag(neg_ff, dvd_in);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      neg_ff  <= neg_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

/* bench/tb_plant_model_euler_step_top.sv */
module tb_plant_model_euler_step_top
   import pmes_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam longint W_MAX = 64'sd2147483647;
   localparam longint W_MIN = -64'sd2147483648;
   localparam int Q_FRAC = 16;
   localparam longint Q_HALF = 64'sd32768;
   localparam longint STOP_LSB = 64'sd66;

   localparam logic [ORDER_WIDTH-1:0] MODE_NONE  = ORDER_WIDTH'(0);
   localparam logic [ORDER_WIDTH-1:0] MODE_SPARE = ORDER_WIDTH'(3);

   localparam int CYCLE_LIMIT = 500000;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 100;
   localparam int RANDOM_EFFORTS = 450;

   typedef struct {
      logic [INDEX_WIDTH-1:0] idx;
      logic [31:0]            data;
   } reg_write_type;

   class euler_plant_tracker;
      logic [ORDER_WIDTH-1:0] order;
      longint dt, growth, fric, stic, mgain, bemf, mass_q;
      longint temp_q, disp_q, speed_q, last_q;
      word_type due_state[$];
      logic due_error[$];
      int errors;
      int compared;
      int steps_by_mode[4];

      function new();
         order = MODE_FIRST;
         dt = 655;
         growth = 6554;
         fric = 65536;
         stic = 65536;
         mgain = 65536;
         bemf = 0;
         mass_q = 6554;
         temp_q = 308019;
         disp_q = 216269;
         speed_q = 0;
         last_q = 0;
         errors = 0;
         compared = 0;
         foreach (steps_by_mode[i]) steps_by_mode[i] = 0;
      endfunction

      function longint clip(longint x);
         if (x > W_MAX) return W_MAX;
         if (x < W_MIN) return W_MIN;
         return x;
      endfunction

      function longint add_clip(longint a, longint b);
         return clip(a + b);
      endfunction

      function longint neg_clip(longint a);
         return (a == W_MIN) ? W_MAX : -a;
      endfunction

      function longint abs_q(longint a);
         return (a < 0) ? -a : a;
      endfunction

      function longint signed_of(bit neg, longint m);
         if (!neg) return (m > W_MAX) ? W_MAX : m;
         return (m > W_MAX + 1) ? W_MIN : -m;
      endfunction

      function longint q_mul(longint a, longint b);
         longint p;
         p = (abs_q(clip(a)) * abs_q(clip(b)) + Q_HALF) >>> Q_FRAC;
         return signed_of((clip(a) < 0) != (clip(b) < 0), p);
      endfunction

      function longint q_div(longint num, longint den);
         longint d, n;
         d = (den == 0) ? 64'sd1 : abs_q(clip(den));
         n = abs_q(clip(num)) <<< Q_FRAC;
         return signed_of((clip(num) < 0) != (clip(den) < 0), (n + d / 2) / d);
      endfunction

      function void set_register(logic [INDEX_WIDTH-1:0] idx, logic [31:0] data);
         case (idx)
            REG_PLANT_ORDER:  order = data[1:0];
            REG_TIME_STEP:    dt = longint'(data[16:0]);
            REG_GROWTH_COEF:  growth = longint'(signed'(data));
            REG_FRICTION:     fric = longint'(data[30:0]);
            REG_STICTION:     stic = longint'(data[30:0]);
            REG_MOTOR_GAIN:   mgain = longint'(signed'(data));
            REG_BACKEMF_GAIN: bemf = longint'(signed'(data));
            REG_MASS:         mass_q = longint'(data[30:0]);
            default: ;
         endcase
      endfunction

      function void note_effort(word_type effort);
         longint e, rate, decel, drive, push_q, accel;
         bit err;
         e = longint'(effort);
         err = 1'b0;
         steps_by_mode[order]++;
         case (order)
            MODE_FIRST: begin
               rate = add_clip(q_mul(growth, temp_q), e);
               temp_q = add_clip(temp_q, q_mul(rate, dt));
               last_q = temp_q;
            end
            MODE_SECOND: begin
               if (abs_q(speed_q) < STOP_LSB) begin
                  speed_q = 0;
                  if (abs_q(e) < stic) e = 0;
               end
               decel = neg_clip(q_mul(speed_q, fric));
               drive = add_clip(e, neg_clip(q_mul(bemf, speed_q)));
               push_q = add_clip(q_mul(mgain, drive), decel);
               accel = q_div(push_q, mass_q);
               speed_q = add_clip(speed_q, q_mul(accel, dt));
               disp_q = add_clip(disp_q, q_mul(speed_q, dt));
               last_q = disp_q;
            end
            default: err = 1'b1;
         endcase
         due_state.push_back(word_type'(last_q[31:0]));
         due_error.push_back(err);
      endfunction

      function void check_state(word_type state, logic mode_err);
         word_type want_state;
         logic want_err;
         if (due_state.size() == 0) begin
            $error("Unexpected result beat: plant_state %0d, mode_error %0b", state, mode_err);
            errors++;
            return;
         end
         want_state = due_state.pop_front();
         want_err = due_error.pop_front();
         compared++;
         if (state !== want_state) begin
            $error("plant_state mismatch: expected %0d, got %0d", want_state, state);
            errors++;
         end
         if (mode_err !== want_err) begin
            $error("mode_error mismatch: expected %0b, got %0b", want_err, mode_err);
            errors++;
         end
      endfunction

      function int pending();
         return due_state.size();
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   word_type               req_control_effort = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   word_type               rsp_plant_state;
   logic                   rsp_mode_error;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [INDEX_WIDTH-1:0] csr_index = '0;
   logic [WORD_WIDTH-1:0]  csr_data = '0;

   euler_plant_tracker tracker;
   reg_write_type staged_writes[$];
   word_type effort_burst[$];

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;
   int cycle_count = 0;
   int sent_count = 0;
   int settings_count = 0;

   plant_model_euler_step_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_control_effort (req_control_effort),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_plant_state    (rsp_plant_state),
      .rsp_mode_error     (rsp_mode_error),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         tracker.check_state(rsp_plant_state, rsp_mode_error);
      end
   end

   // A requested hold keeps the result side stalled long enough for the block to fill.
   always @(negedge clock) begin
      if (hold_left == 0 && hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   function automatic void stage_write(logic [INDEX_WIDTH-1:0] idx, logic [31:0] data);
      reg_write_type w;
      w.idx = idx;
      w.data = data;
      staged_writes.push_back(w);
   endfunction

   function automatic logic [31:0] pick_extreme(logic [31:0] lo, logic [31:0] hi);
      return $urandom_range(1) ? hi : lo;
   endfunction

   function automatic word_type pick_effort();
      int unsigned r;
      longint near_val;
      word_type e;
      r = $urandom_range(99);
      if (r < 10) begin
         case ($urandom_range(4))
            0: e = WORD_MAX;
            1: e = WORD_MIN;
            2: e = '0;
            3: e = -32'sd1;
            default: e = 32'sd1;
         endcase
      end else if (r < 35) begin
         e = word_type'($urandom());
      end else if (r < 65) begin
         e = word_type'(int'($urandom_range(262144)) - 131072);
      end else begin
         near_val = tracker.stic + longint'($urandom_range(40)) - 20;
         if ($urandom_range(1)) near_val = -near_val;
         e = word_type'(near_val[31:0]);
      end
      return e;
   endfunction

   task automatic apply_settings();
      while (tracker.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      foreach (staged_writes[i]) begin
         csr_valid <= 1'b1;
         csr_index <= staged_writes[i].idx;
         csr_data <= staged_writes[i].data;
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         tracker.set_register(staged_writes[i].idx, staged_writes[i].data);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
      staged_writes.delete();
      settings_count++;
   endtask

   task automatic send_burst();
      foreach (effort_burst[i]) begin
         while ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
         req_valid <= 1'b1;
         req_control_effort <= effort_burst[i];
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         tracker.note_effort(effort_burst[i]);
         sent_count++;
         @(negedge clock);
      end
      req_valid <= 1'b0;
      effort_burst.delete();
   endtask

   task automatic plan_settings();
      int unsigned kind, r;
      logic [ORDER_WIDTH-1:0] mode;
      logic [31:0] d;
      kind = $urandom_range(99);
      r = $urandom_range(99);
      if (r < 40) mode = MODE_FIRST;
      else if (r < 85) mode = MODE_SECOND;
      else mode = $urandom_range(1) ? MODE_NONE : MODE_SPARE;
      if (kind < 55) begin
         stage_write(REG_PLANT_ORDER, 32'(mode));
         stage_write(REG_TIME_STEP, 32'($urandom_range(6554, 1)));
         stage_write(REG_GROWTH_COEF, 32'(int'($urandom_range(131072)) - 65536));
         stage_write(REG_FRICTION, {1'($urandom_range(1)), 31'($urandom_range(131072))});
         stage_write(REG_STICTION, {1'($urandom_range(1)), 31'($urandom_range(200000))});
         stage_write(REG_MOTOR_GAIN, 32'(int'($urandom_range(262144)) - 131072));
         stage_write(REG_BACKEMF_GAIN, 32'(int'($urandom_range(131072)) - 65536));
         stage_write(REG_MASS, {1'($urandom_range(1)), 31'($urandom_range(200000, 1000))});
      end else if (kind < 80) begin
         d = $urandom();
         d[1:0] = mode;
         stage_write(REG_PLANT_ORDER, d);
         stage_write(REG_TIME_STEP, $urandom());
         stage_write(REG_GROWTH_COEF, $urandom());
         stage_write(REG_FRICTION, $urandom());
         stage_write(REG_STICTION, $urandom());
         stage_write(REG_MOTOR_GAIN, $urandom());
         stage_write(REG_BACKEMF_GAIN, $urandom());
         stage_write(REG_MASS, $urandom());
      end else begin
         stage_write(REG_PLANT_ORDER, 32'(mode));
         case ($urandom_range(3))
            0: stage_write(REG_TIME_STEP, 32'd0);
            1: stage_write(REG_TIME_STEP, 32'd1);
            2: stage_write(REG_TIME_STEP, 32'd65536);
            default: stage_write(REG_TIME_STEP, 32'h0001_FFFF);
         endcase
         stage_write(REG_GROWTH_COEF, pick_extreme(32'h8000_0000, 32'h7FFF_FFFF));
         stage_write(REG_FRICTION, pick_extreme(32'h0, 32'hFFFF_FFFF));
         stage_write(REG_STICTION, pick_extreme(32'h0, 32'hFFFF_FFFF));
         stage_write(REG_MOTOR_GAIN, pick_extreme(32'h8000_0000, 32'h7FFF_FFFF));
         stage_write(REG_BACKEMF_GAIN, pick_extreme(32'h8000_0000, 32'h7FFF_FFFF));
         stage_write(REG_MASS, pick_extreme(32'h1, 32'hFFFF_FFFF));
      end
   endtask

   initial begin
      int random_sent;
      int phase;
      int n;
      bit held_first, held_second;
      tracker = new();
      random_sent = 0;
      held_first = 1'b0;
      held_second = 1'b0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      effort_burst = '{32'sd0, 32'sd1, -32'sd1, WORD_MAX, WORD_MIN, 32'sd65536};
      send_burst();

      stage_write(REG_PLANT_ORDER, 32'(MODE_SECOND));
      apply_settings();
      effort_burst = '{32'sd1000, -32'sd65535, 32'sd65536, WORD_MAX, WORD_MIN, -32'sd200000};
      send_burst();

      stage_write(REG_PLANT_ORDER, 32'(MODE_NONE));
      apply_settings();
      effort_burst = '{32'sd12345, WORD_MIN};
      send_burst();

      stage_write(REG_PLANT_ORDER, 32'(MODE_SPARE));
      apply_settings();
      effort_burst = '{-32'sd7, WORD_MAX};
      send_burst();

      stage_write(REG_PLANT_ORDER, 32'(MODE_SECOND));
      stage_write(REG_MASS, 32'd0);
      stage_write(REG_TIME_STEP, 32'd0);
      apply_settings();
      effort_burst = '{32'sd300000, -32'sd300000};
      send_burst();

      stage_write(REG_PLANT_ORDER, 32'(MODE_FIRST));
      apply_settings();
      effort_burst = '{WORD_MAX};
      send_burst();

      stage_write(REG_PLANT_ORDER, 32'(MODE_SECOND));
      stage_write(REG_TIME_STEP, 32'h0001_FFFF);
      stage_write(REG_GROWTH_COEF, 32'h8000_0000);
      stage_write(REG_FRICTION, 32'h7FFF_FFFF);
      stage_write(REG_STICTION, 32'h7FFF_FFFF);
      stage_write(REG_MOTOR_GAIN, 32'h8000_0000);
      stage_write(REG_BACKEMF_GAIN, 32'h7FFF_FFFF);
      stage_write(REG_MASS, 32'h7FFF_FFFF);
      apply_settings();
      effort_burst = '{WORD_MIN, 32'sd5, WORD_MAX};
      send_burst();

      stage_write(REG_PLANT_ORDER, 32'(MODE_FIRST));
      stage_write(REG_GROWTH_COEF, 32'h7FFF_FFFF);
      stage_write(REG_TIME_STEP, 32'd1);
      apply_settings();
      effort_burst = '{-32'sd1, 32'sd0};
      send_burst();

      while (random_sent < RANDOM_EFFORTS) begin
         phase = (random_sent * 4) / RANDOM_EFFORTS;
         case (phase)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 76;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 76;
            end
            default: begin
               send_idle_pct = 34;
               rsp_stall_pct = 34;
            end
         endcase
         plan_settings();
         apply_settings();
         n = $urandom_range(28, 8);
         if ((phase == 0 && !held_first) || (phase == 2 && !held_second)) begin
            if (phase == 0) held_first = 1'b1;
            else held_second = 1'b1;
            hold_requests++;
            n = 20;
         end
         repeat (n) effort_burst.push_back(pick_effort());
         send_burst();
         random_sent += n;
      end

      while (tracker.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $write("Run covered %0d efforts under %0d register settings: ", sent_count,
             settings_count);
      $display("%0d first-order, %0d second-order and %0d invalid-mode steps.",
               tracker.steps_by_mode[MODE_FIRST], tracker.steps_by_mode[MODE_SECOND],
               tracker.steps_by_mode[MODE_NONE] + tracker.steps_by_mode[MODE_SPARE]);
      $display("%0d results compared across four idling patterns, with %0d long output stalls.",
               tracker.compared, hold_requests);
      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

/* plant_model_euler_step_top.f */
design/pmes_pkg.sv
design/pmes_mul.sv
design/pmes_div.sv
design/plant_model_euler_step_top.sv
bench/tb_plant_model_euler_step_top.sv
